### rtl/ctrt_pkg.sv
// Shared types and constants for the chunked transfer reassembly tracker.
package ctrt_pkg;

   localparam int unsigned SLOTS_DEFAULT = 8;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_CHUNK = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;
   localparam logic [1:0] FUNC_TICK  = 2'd3;

   localparam logic [2:0] EV_PROGRESS  = 3'd0;
   localparam logic [2:0] EV_COMPLETE  = 3'd1;
   localparam logic [2:0] EV_TOO_LARGE = 3'd2;
   localparam logic [2:0] EV_TOO_MANY  = 3'd3;
   localparam logic [2:0] EV_NO_ROOM   = 3'd4;
   localparam logic [2:0] EV_BAD_CHUNK = 3'd5;
   localparam logic [2:0] EV_ENDED     = 3'd6;
   localparam logic [2:0] EV_STALLED   = 3'd7;

   localparam logic [1:0] CSR_MAX_TRANSFER = 2'd0;
   localparam logic [1:0] CSR_MAX_OPEN     = 2'd1;
   localparam logic [1:0] CSR_MAX_RESERVED = 2'd2;
   localparam logic [1:0] CSR_STALL_TICKS  = 2'd3;

   // Command to one slot cell for one cycle; its data fields are the same for every cell.
   typedef struct packed {
      logic        load;     // write the new transfer into this cell
      logic        drop;     // free this cell
      logic        chunk_ok; // apply an accepted chunk
      logic [15:0] tag;
      logic [31:0] size;
      logic [31:0] seq;
      logic [19:0] len;
      logic [31:0] now;
   } cell_cmd_type;

   // What one cell reports about itself.
   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        stale;
      logic [15:0] tag;
      logic [31:0] size;
      logic [31:0] received;
      logic [31:0] expected_seq;
   } cell_stat_type;

endpackage

### rtl/ctrt_cell.sv
// One slot cell: holds a single open transfer and reports match and age.
module ctrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           match_id,
   input  logic [31:0]           stall_ticks,
   input  ctrt_pkg::cell_cmd_type cmd,
   output ctrt_pkg::cell_stat_type stat
);

   logic        valid_ff, valid_in;
   logic [15:0] tag_ff;
   logic [31:0] size_ff, received_ff, seq_ff, last_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.drop) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff      <= cmd.tag;
         size_ff     <= cmd.size;
         received_ff <= '0;
         seq_ff      <= '0;
         last_ff     <= cmd.now;
      end else if (cmd.chunk_ok) begin
         received_ff <= received_ff + {12'd0, cmd.len};
         seq_ff      <= cmd.seq + 32'd1;
         last_ff     <= cmd.now;
      end
   end

   always_comb begin
      stat.valid        = valid_ff;
      stat.hit          = valid_ff && (tag_ff == match_id);
      stat.stale        = valid_ff && ((cmd.now - last_ff) > stall_ticks);
      stat.tag          = tag_ff;
      stat.size         = size_ff;
      stat.received     = received_ff;
      stat.expected_seq = seq_ff;
   end

endmodule

### rtl/chunked_transfer_reassembly_tracker_unit.sv
// Top level of the chunked transfer reassembly tracker.
// A row of SLOTS cells holds the open transfers; an item is decoded in the
// cycle it is accepted against all cells at once and its result sits in the
// output register from the next cycle, so begin, chunk and end items can
// follow back to back while the result side keeps up. A tick holds the input
// while the sweep walks the cells one per cycle, giving at most one eviction
// each cycle, and the sweep pauses for as long as an eviction waits on a
// stalled output register. The block accepts a new item whenever no sweep is
// running and the output register is empty or being emptied in the same
// cycle.
module chunked_transfer_reassembly_tracker_unit #(
   parameter int unsigned SLOTS = ctrt_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_transfer_id,
   input  logic [31:0] req_declared_size,
   input  logic [31:0] req_chunk_seq,
   input  logic [19:0] req_chunk_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_result_id,
   output logic [31:0] rsp_write_offset,
   output logic [31:0] rsp_received_bytes,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   logic [31:0] max_transfer_ff, max_reserved_ff, stall_ticks_ff;
   logic [3:0]  max_open_ff;
   logic [32:0] in_use_ff, in_use_in;
   logic [31:0] now_ff, now_in;
   state_type   state_ff, state_in;
   logic [IW-1:0] ptr_ff, ptr_in;

   logic        ov_ff, ov_in;
   logic [2:0]  oev_ff, oev_in;
   logic [15:0] oid_ff, oid_in;
   logic [31:0] ooff_ff, ooff_in, orcv_ff, orcv_in;
   logic        olast_ff, olast_in;

   ctrt_pkg::cell_cmd_type  cmd [SLOTS];
   ctrt_pkg::cell_stat_type stat [SLOTS];

   logic out_free, accept;
   assign out_free  = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Cell row.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ctrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .match_id   (req_transfer_id),
         .stall_ticks(stall_ticks_ff),
         .cmd        (cmd[g]),
         .stat       (stat[g])
      );
   end

   // Parallel lookup over the cells.
   logic          hit_any, free_any;
   logic [IW-1:0] hit_idx, free_idx;
   logic [CW-1:0] open_cnt;
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      open_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (stat[i].hit && !hit_any) begin
            hit_any = 1'b1;
            hit_idx = IW'(i);
         end
         if (stat[i].valid && !stat[i].hit) begin
            open_cnt = open_cnt + CW'(1);
         end
         if (!stat[i].valid && !free_any) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   ctrt_pkg::cell_stat_type hs, ps;
   assign hs = stat[hit_idx];
   assign ps = stat[ptr_ff];

   logic [32:0] used_b;
   logic [33:0] need_b;
   logic [IW-1:0] tgt_idx;
   logic        tgt_ok;
   logic [32:0] rcv_sum;
   logic        chunk_bad;
   logic        too_many;
   always_comb begin
      // A live id counts as released; at most one slot matches a given id.
      used_b    = hit_any ? (in_use_ff - {1'b0, hs.size}) : in_use_ff;
      need_b    = {1'b0, used_b} + {2'd0, req_declared_size};
      tgt_idx   = hit_any ? hit_idx : free_idx;
      tgt_ok    = hit_any || free_any;
      too_many  = ({{(32-CW){1'b0}}, open_cnt} >= {28'd0, max_open_ff}) || !tgt_ok;
      rcv_sum   = {1'b0, hs.received} + {13'd0, req_chunk_len};
      chunk_bad = (req_chunk_seq != hs.expected_seq) || (rcv_sum > {1'b0, hs.size});
   end

   // Next-state and cell commands.
   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      in_use_in = in_use_ff;
      now_in    = now_ff;
      ov_in     = ov_ff && rsp_stall;
      oev_in    = oev_ff;
      oid_in    = oid_ff;
      ooff_in   = ooff_ff;
      orcv_in   = orcv_ff;
      olast_in  = olast_ff;
      for (int i = 0; i < SLOTS; i++) begin
         cmd[i].load     = 1'b0;
         cmd[i].drop     = 1'b0;
         cmd[i].chunk_ok = 1'b0;
         cmd[i].tag      = req_transfer_id;
         cmd[i].size     = req_declared_size;
         cmd[i].seq      = req_chunk_seq;
         cmd[i].len      = req_chunk_len;
         cmd[i].now      = now_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               oid_in   = req_transfer_id;
               ooff_in  = '0;
               orcv_in  = '0;
               olast_in = 1'b1;
               unique case (req_func)
                  ctrt_pkg::FUNC_BEGIN: begin
                     priority if (req_declared_size > max_transfer_ff) begin
                        ov_in  = 1'b1;
                        oev_in = ctrt_pkg::EV_TOO_LARGE;
                     end else if (too_many) begin
                        ov_in  = 1'b1;
                        oev_in = ctrt_pkg::EV_TOO_MANY;
                     end else if (need_b > {2'd0, max_reserved_ff}) begin
                        ov_in  = 1'b1;
                        oev_in = ctrt_pkg::EV_NO_ROOM;
                     end else begin
                        in_use_in         = need_b[32:0];
                        cmd[tgt_idx].load = 1'b1;
                     end
                  end
                  ctrt_pkg::FUNC_CHUNK: begin
                     if (hit_any) begin
                        ov_in = 1'b1;
                        if (chunk_bad) begin
                           oev_in            = ctrt_pkg::EV_BAD_CHUNK;
                           orcv_in           = hs.received;
                           in_use_in         = used_b;
                           cmd[hit_idx].drop = 1'b1;
                        end else begin
                           oev_in                = ctrt_pkg::EV_PROGRESS;
                           ooff_in               = hs.received;
                           orcv_in               = rcv_sum[31:0];
                           cmd[hit_idx].chunk_ok = 1'b1;
                        end
                     end
                  end
                  ctrt_pkg::FUNC_END: begin
                     if (hit_any) begin
                        ov_in  = 1'b1;
                        oev_in = (hs.received == hs.size) ? ctrt_pkg::EV_COMPLETE
                                                          : ctrt_pkg::EV_ENDED;
                        orcv_in           = hs.received;
                        in_use_in         = used_b;
                        cmd[hit_idx].drop = 1'b1;
                     end
                  end
                  ctrt_pkg::FUNC_TICK: begin
                     now_in   = now_ff + 32'd1;
                     ptr_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            // One cell per cycle; hold while an eviction cannot be handed over.
            if (!ps.stale || out_free) begin
               if (ps.stale) begin
                  ov_in            = 1'b1;
                  oev_in           = ctrt_pkg::EV_STALLED;
                  oid_in           = ps.tag;
                  ooff_in          = '0;
                  orcv_in          = ps.received;
                  in_use_in        = in_use_ff - {1'b0, ps.size};
                  cmd[ptr_ff].drop = 1'b1;
               end
               // Mark last if no later cell is stale.
               olast_in = 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (IW'(i) > ptr_ff && stat[i].stale) begin
                     olast_in = 1'b0;
                  end
               end
               if (32'(ptr_ff) == SLOTS - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + IW'(1);
               end
               if (!ps.stale) begin
                  olast_in = olast_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_transfer_ff <= 32'd67108864;
         max_open_ff     <= 4'd8;
         max_reserved_ff <= 32'd268435456;
         stall_ticks_ff  <= 32'd1000;
         in_use_ff       <= '0;
         now_ff          <= '0;
         state_ff        <= ST_IDLE;
         ptr_ff          <= '0;
         ov_ff           <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ctrt_pkg::CSR_MAX_TRANSFER: max_transfer_ff <= csr_data;
               ctrt_pkg::CSR_MAX_OPEN:     max_open_ff     <= csr_data[3:0];
               ctrt_pkg::CSR_MAX_RESERVED: max_reserved_ff <= csr_data;
               ctrt_pkg::CSR_STALL_TICKS:  stall_ticks_ff  <= csr_data;
               default: ;
            endcase
         end
         in_use_ff <= in_use_in;
         now_ff    <= now_in;
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      oev_ff   <= oev_in;
      oid_ff   <= oid_in;
      ooff_ff  <= ooff_in;
      orcv_ff  <= orcv_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid          = ov_ff;
   assign rsp_event_res      = oev_ff;
   assign rsp_result_id      = oid_ff;
   assign rsp_write_offset   = ooff_ff;
   assign rsp_received_bytes = orcv_ff;
   assign rsp_last           = olast_ff;

endmodule

### verif/tb.sv
// Self-checking testbench for the chunked transfer reassembly tracker.
`timescale 1ns / 1ps

class tracker_scoreboard;
   typedef struct packed {
      logic [2:0]  ev;
      logic [15:0] id;
      logic [31:0] off;
      logic [31:0] rcv;
      logic        last;
   } event_t;

   // Configuration and tracker state copy.
   bit [31:0] max_xfer, max_resv, stall_lim;
   bit [3:0]  max_open;
   bit        s_valid[8];
   bit [15:0] s_tag[8];
   bit [31:0] s_size[8], s_rcv[8], s_seq[8], s_act[8];
   bit [32:0] used_bytes;
   bit [31:0] now;
   event_t    pending[$];
   int        errors;

   function new();
      max_xfer = 32'd67108864; max_open = 4'd8;
      max_resv = 32'd268435456; stall_lim = 32'd1000;
      foreach (s_valid[i]) s_valid[i] = 0;
      used_bytes = 0; now = 0; errors = 0;
   endfunction

   function void set_reg(bit [1:0] idx, bit [31:0] v);
      case (idx)
         ctrt_pkg::CSR_MAX_TRANSFER: max_xfer = v;
         ctrt_pkg::CSR_MAX_OPEN:     max_open = v[3:0];
         ctrt_pkg::CSR_MAX_RESERVED: max_resv = v;
         default:                    stall_lim = v;
      endcase
   endfunction

   function int lookup(bit [15:0] id);
      for (int i = 0; i < 8; i++) if (s_valid[i] && s_tag[i] == id) return i;
      return -1;
   endfunction

   function void push(bit [2:0] ev, bit [15:0] id, bit [31:0] off, bit [31:0] rcv);
      event_t e;
      e.ev = ev; e.id = id; e.off = off; e.rcv = rcv; e.last = 0;
      pending.push_back(e);
   endfunction

   function void note_item(bit [1:0] fn, bit [15:0] id, bit [31:0] size,
                           bit [31:0] seq, bit [19:0] len);
      int old, fs, s, n0;
      int unsigned open;
      bit [32:0] used;
      bit [2:0] ev;
      bit refused;
      n0 = pending.size();
      if (fn == ctrt_pkg::FUNC_BEGIN) begin
         old = lookup(id); open = 0; fs = -1; used = used_bytes; refused = 1;
         for (int i = 0; i < 8; i++)
            if (s_valid[i] && i != old) open++;
            else if (fs < 0) fs = i;
         if (old >= 0) begin
            used = used - s_size[old]; fs = old;
         end
         if (size > max_xfer) ev = ctrt_pkg::EV_TOO_LARGE;
         else if (open >= max_open || fs < 0) ev = ctrt_pkg::EV_TOO_MANY;
         else if (used + {1'b0, size} > {1'b0, max_resv}) ev = ctrt_pkg::EV_NO_ROOM;
         else refused = 0;
         if (refused) push(ev, id, 0, 0);
         else begin
            used_bytes = used + size;
            s_valid[fs] = 1; s_tag[fs] = id; s_size[fs] = size;
            s_rcv[fs] = 0; s_seq[fs] = 0; s_act[fs] = now;
         end
      end else if (fn == ctrt_pkg::FUNC_CHUNK) begin
         s = lookup(id);
         if (s >= 0) begin
            if (seq != s_seq[s] || {1'b0, s_rcv[s]} + len > {1'b0, s_size[s]}) begin
               push(ctrt_pkg::EV_BAD_CHUNK, id, 0, s_rcv[s]);
               used_bytes -= s_size[s]; s_valid[s] = 0;
            end else begin
               push(ctrt_pkg::EV_PROGRESS, id, s_rcv[s], s_rcv[s] + len);
               s_rcv[s] += len; s_seq[s] = seq + 1; s_act[s] = now;
            end
         end
      end else if (fn == ctrt_pkg::FUNC_END) begin
         s = lookup(id);
         if (s >= 0) begin
            push(s_rcv[s] == s_size[s] ? ctrt_pkg::EV_COMPLETE : ctrt_pkg::EV_ENDED,
                 id, 0, s_rcv[s]);
            used_bytes -= s_size[s]; s_valid[s] = 0;
         end
      end else begin
         now = now + 1;
         for (int i = 0; i < 8; i++)
            if (s_valid[i] && (now - s_act[i]) > stall_lim) begin
               push(ctrt_pkg::EV_STALLED, s_tag[i], 0, s_rcv[i]);
               used_bytes -= s_size[i]; s_valid[i] = 0;
            end
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1;
   endfunction

   function void check_result(event_t got);
      event_t want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result %p", got);
         return;
      end
      want = pending.pop_front();
      if (want != got) begin
         errors++;
         if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
   endfunction
endclass

module tb;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready, rsp_last;
   logic [1:0]  req_func = 0, csr_index = 0;
   logic [15:0] req_transfer_id = 0, rsp_result_id;
   logic [31:0] req_declared_size = 0, req_chunk_seq = 0, csr_data = 0;
   logic [19:0] req_chunk_len = 0;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_write_offset, rsp_received_bytes;

   tracker_scoreboard sb = new();
   int  cycles = 0;
   int  sink_mode = 0;   // 0 random stalls, 1 no stalls, 2 long hold-off
   bit  quiet_src = 0;
   bit  done = 0;
   // Shadow of the ids the sender uses for well-formed sequences.
   bit [15:0] ids[8];
   bit [31:0] nseq[8];

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   chunked_transfer_reassembly_tracker_unit dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Result side: stall pattern and checking.
   int hold = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_event_res, rsp_result_id, rsp_write_offset,
                          rsp_received_bytes, rsp_last});
      if (sink_mode == 2 && hold == 0) hold = 300;
      if (hold > 0) begin
         hold = hold - 1;
         rsp_stall <= 1;
         if (hold == 0) sink_mode = 0;
      end else
         rsp_stall <= (sink_mode == 0) ? ($urandom_range(99) < 37) : 1'b0;
   end

   // Valid stays high after a transfer until the next item or an idle cycle replaces it.
   task automatic send(bit [1:0] fn, bit [15:0] id, bit [31:0] size,
                       bit [31:0] seq, bit [19:0] len);
      while (!quiet_src && $urandom_range(99) < 37) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_func <= fn; req_transfer_id <= id;
      req_declared_size <= size; req_chunk_seq <= seq; req_chunk_len <= len;
      do @(posedge clock); while (req_stall);
      sb.note_item(fn, id, size, seq, len);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(bit [1:0] idx, bit [31:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
   endtask

   task automatic set_all(bit [31:0] mx, bit [3:0] mo, bit [31:0] mr, bit [31:0] st);
      drain();
      write_reg(ctrt_pkg::CSR_MAX_TRANSFER, mx);
      write_reg(ctrt_pkg::CSR_MAX_OPEN, {28'd0, mo});
      write_reg(ctrt_pkg::CSR_MAX_RESERVED, mr);
      write_reg(ctrt_pkg::CSR_STALL_TICKS, st);
      csr_valid <= 0;
   endtask

   // Mostly well-formed traffic over a small pool of ids, with random noise.
   task automatic random_item();
      int k, r;
      bit [19:0] len;
      k = $urandom_range(7);
      r = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(64));
      if (r < 20) begin
         nseq[k] = 0;
         send(ctrt_pkg::FUNC_BEGIN, ids[k],
              ($urandom_range(9) == 0) ? $urandom : $urandom_range(400),
              $urandom, 20'($urandom));
      end else if (r < 60) begin
         send(ctrt_pkg::FUNC_CHUNK, ids[k], $urandom,
              ($urandom_range(9) == 0) ? $urandom : nseq[k], len);
         nseq[k]++;
      end else if (r < 75)
         send(ctrt_pkg::FUNC_END, ids[k], $urandom, $urandom, 20'($urandom));
      else if (r < 92)
         send(ctrt_pkg::FUNC_TICK, 16'($urandom), $urandom, $urandom, 20'($urandom));
      else send(2'($urandom), 16'($urandom), $urandom, $urandom, 20'($urandom));
   endtask

   initial begin
      foreach (ids[i]) begin
         ids[i] = (i == 7) ? 16'hFFFF : 16'($urandom);
         nseq[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, refusals, replacement of a live id, bad chunks.
      send(ctrt_pkg::FUNC_BEGIN, 16'h0000, 32'd100, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'hFFFF, 32'hFFFFFFFF, 0, 0);
      send(ctrt_pkg::FUNC_CHUNK, 16'h0000, 0, 0, 20'd60);
      send(ctrt_pkg::FUNC_CHUNK, 16'h0000, 0, 1, 20'd40);
      send(ctrt_pkg::FUNC_END, 16'h0000, 0, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0001, 32'd10, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0001, 32'd20, 0, 0);
      send(ctrt_pkg::FUNC_CHUNK, 16'h0001, 0, 5, 20'd1);
      send(ctrt_pkg::FUNC_CHUNK, 16'h0002, 0, 0, 20'd1);
      send(ctrt_pkg::FUNC_END, 16'h0002, 0, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0003, 32'd5, 0, 0);
      send(ctrt_pkg::FUNC_CHUNK, 16'h0003, 0, 0, 20'hFFFFF);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0004, 32'd5, 0, 0);
      send(ctrt_pkg::FUNC_END, 16'h0004, 0, 0, 0);
      set_all(32'hFFFFFFFF, 4'd2, 32'd50, 32'd2);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0010, 32'd30, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0011, 32'd30, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0010, 32'd40, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0012, 32'd1, 0, 0);
      repeat (4) send(ctrt_pkg::FUNC_TICK, 16'hFFFF, 0, 0, 0);
      set_all(32'hFFFFFFFF, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 9; i++)
         send(ctrt_pkg::FUNC_BEGIN, 16'(16'h20 + i), 32'hFFFFFFFF, 0, 0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0030, 32'd8, 0, 0);
      send(ctrt_pkg::FUNC_TICK, 0, 0, 0, 0);
      set_all(32'd0, 4'd0, 32'd0, 32'd0);
      send(ctrt_pkg::FUNC_BEGIN, 16'h0040, 32'd0, 0, 0);
      send(ctrt_pkg::FUNC_TICK, 0, 0, 0, 0);
      // Random phases over several settings; stalls are evicted by the tick sweep.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_all(32'd300, 4'd8, 32'd1200, 32'd6);
            1: set_all(32'd400, 4'd3, 32'd2000, 32'd1);
            2: set_all(32'hFFFFFFFF, 4'd8, 32'hFFFFFFFF, 32'd20);
            3: set_all(32'd200, 4'd15, 32'd900, 32'd0);
            default: set_all(32'h04000000, 4'd8, 32'h10000000, 32'd3);
         endcase
         if (ph == 1) quiet_src = 1;
         if (ph == 2) begin
            quiet_src = 0; sink_mode = 2;
         end
         // Neither side idles in this phase.
         if (ph == 3) begin
            quiet_src = 1; sink_mode = 1;
         end
         if (ph == 4) begin
            quiet_src = 0; sink_mode = 0;
         end
         for (int i = 0; i < 37; i++) random_item();
         // Sender stops until every result is back.
         if (ph == 2) drain();
         // Eight begins with fresh ids, then tick sweeps that evict every open slot.
         if (ph == 2) begin
            set_all(32'hFFFFFFFF, 4'd8, 32'hFFFFFFFF, 32'd0);
            for (int i = 0; i < 8; i++)
               send(ctrt_pkg::FUNC_BEGIN, ids[i] ^ 16'h8000, 32'd9, 0, 0);
            repeat (2) send(ctrt_pkg::FUNC_TICK, 0, 0, 0, 0);
         end
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
